// ----- rtl/core/ball_motion_renormalize_defines.svh -----
// Assertion macros for the ball motion block.
// Define ASSERT_OFF to compile them away.
`ifndef BALL_MOTION_RENORMALIZE_DEFINES_SVH
`define BALL_MOTION_RENORMALIZE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BMR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define BMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/bmr_pkg.sv -----
`timescale 1ns / 1ps

package bmr_pkg;

    localparam int POS_WIDTH   = 22;
    localparam int VEL_WIDTH   = 16;
    localparam int LOAD_WIDTH  = 22;
    localparam int SPEED_WIDTH = 15;

    localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = SPEED_WIDTH'(1024);

    // serial multiplier operand width: covers |vel| and target speed
    localparam int MUL_W  = (VEL_WIDTH > SPEED_WIDTH) ? VEL_WIDTH : SPEED_WIDTH;
    localparam int SQ_W   = 2 * VEL_WIDTH;           // vx^2 + vy^2
    localparam int ROOT_W = VEL_WIDTH;               // magnitude
    localparam int NUM_W  = VEL_WIDTH + SPEED_WIDTH; // |v| * speed

    localparam int EXT_PV = (POS_WIDTH > VEL_WIDTH) ? POS_WIDTH : VEL_WIDTH;
    localparam int EXT_W  = ((EXT_PV > LOAD_WIDTH) ? EXT_PV : LOAD_WIDTH) + 1;

    localparam int IN_USER_W  = 3;
    localparam int IN_DATA_W  = ((2 * LOAD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * POS_WIDTH + 2 * VEL_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FUNC_ADVANCE  = 2'd0,
        FUNC_RENORM   = 2'd1,
        FUNC_LOAD_VEL = 2'd2,
        FUNC_LOAD_POS = 2'd3
    } t_func;

endpackage

// ----- rtl/core/bmr_serial_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module bmr_serial_mul
    import bmr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic               o_done,
    output logic [2*MUL_W-1:0] o_product
);

    localparam int CW = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [MUL_W-1:0] r_a;
    logic [MUL_W-1:0] r_hi;
    logic [MUL_W-1:0] r_lo;
    logic [MUL_W:0]   sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MUL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[MUL_W:1];
            r_lo <= {sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

// ----- rtl/core/bmr_isqrt.sv -----
`timescale 1ns / 1ps

// Digit-by-digit integer square root: two radicand bits in, one root bit out per cycle.
module bmr_isqrt
    import bmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CW = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [SQ_W-1:0]   r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              fits;
    logic [ROOT_W+2:0] rem_sub;

    assign rem_sh  = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign fits    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= fits ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/core/bmr_serial_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
module bmr_serial_div
    import bmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [ROOT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quotient
);

    localparam int CW = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [ROOT_W-1:0] r_div;
    logic [ROOT_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [ROOT_W:0]   trial;
    logic              fits;
    logic [ROOT_W:0]   rem_sub;

    assign trial   = {r_rem, r_q[NUM_W-1]};
    assign fits    = (trial >= {1'b0, r_div});
    assign rem_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[ROOT_W-1:0] : trial[ROOT_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- rtl/core/ball_motion_renormalize.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Contents
// s_axis    in   tvalid/tready              tuser: func, hold; tdata: load_a, load_b
// m_axis    out  tvalid/tready              tdata: x_pos, y_pos, x_vel, y_vel
// cfg       in   write enable, no stall     target_speed
//
// Advance and load requests pass S_DONE on their way to the output register.
// Renormalize runs two lanes of serial multiply for the squares, the bit-pair
// square root, serial multiply by speed, then two restoring dividers; each
// unit works one bit per cycle.
// One request is worked on at a time; the next is taken once the result is handed
// to the output register, which may still be waiting on m_axis tready.
// Reset is synchronous, active low; position and velocity clear, speed reads 4.0.
`include "ball_motion_renormalize_defines.svh"

module ball_motion_renormalize
    import bmr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SPEED_WIDTH-1:0] i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,   // load_a, load_b, zero pad
    input  logic [IN_USER_W-1:0]   i_s_axis_tuser,   // func[1:0], hold_on_paddle
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata    // x_pos, y_pos, x_vel, y_vel, pad
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQR   = 6'b000010,
        S_ROOT  = 6'b000100,
        S_SCALE = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic signed [EXT_W-1:0] POS_MAX_E =
        EXT_W'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] POS_MIN_E = -POS_MAX_E - EXT_W'(1);
    localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'((64'd1 << (VEL_WIDTH - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(64'd1 << (VEL_WIDTH - 1));
    localparam logic signed [VEL_WIDTH-1:0] VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
    localparam logic signed [VEL_WIDTH-1:0] VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [POS_WIDTH-1:0] res;
        if (v > POS_MAX_E) begin
            res = POS_MAX_E[POS_WIDTH-1:0];
        end else if (v < POS_MIN_E) begin
            res = POS_MIN_E[POS_WIDTH-1:0];
        end else begin
            res = v[POS_WIDTH-1:0];
        end
        return res;
    endfunction

    // quotient magnitude plus sign back to signed velocity, saturated
    function automatic logic signed [VEL_WIDTH-1:0] sat_vel(
        input logic             neg,
        input logic [NUM_W-1:0] q
    );
        logic [NUM_W-1:0]            neg_q;
        logic signed [VEL_WIDTH-1:0] res;
        neg_q = ~q + NUM_W'(1);
        if (!neg) begin
            res = (q > Q_POS_LIM) ? VEL_MAX : $signed(q[VEL_WIDTH-1:0]);
        end else begin
            res = (q > Q_NEG_LIM) ? VEL_MIN : $signed(neg_q[VEL_WIDTH-1:0]);
        end
        return res;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [SPEED_WIDTH-1:0]       r_speed;
    logic signed [POS_WIDTH-1:0]  r_pos_x;
    logic signed [POS_WIDTH-1:0]  r_pos_y;
    logic signed [VEL_WIDTH-1:0]  r_vel_x;
    logic signed [VEL_WIDTH-1:0]  r_vel_y;
    logic signed [POS_WIDTH-1:0]  n_pos_x;
    logic signed [POS_WIDTH-1:0]  n_pos_y;
    logic signed [VEL_WIDTH-1:0]  n_vel_x;
    logic signed [VEL_WIDTH-1:0]  n_vel_y;

    t_func                        r_func;
    logic                         r_hold;
    logic signed [LOAD_WIDTH-1:0] r_load_a;
    logic signed [LOAD_WIDTH-1:0] r_load_b;
    logic                         r_skip;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic in_acc;
    logic commit;
    t_func in_func;

    logic [VEL_WIDTH-1:0] vx_u;
    logic [VEL_WIDTH-1:0] vy_u;
    logic [VEL_WIDTH-1:0] abs_x;
    logic [VEL_WIDTH-1:0] abs_y;

    logic               mul_start;
    logic [MUL_W-1:0]   mul_b_x;
    logic [MUL_W-1:0]   mul_b_y;
    logic               mul_done_x;
    logic               mul_done_y;
    logic [2*MUL_W-1:0] prod_x;
    logic [2*MUL_W-1:0] prod_y;

    logic              sqrt_start;
    logic [SQ_W-1:0]   radicand;
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;

    logic             div_start;
    logic             div_done_x;
    logic             div_done_y;
    logic [NUM_W-1:0] quot_x;
    logic [NUM_W-1:0] quot_y;

    logic signed [EXT_W-1:0] sum_x;
    logic signed [EXT_W-1:0] sum_y;
    logic signed [EXT_W-1:0] ext_a;
    logic signed [EXT_W-1:0] ext_b;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_func = t_func'(i_s_axis_tuser[1:0]);
    assign commit  = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign vx_u  = r_vel_x;
    assign vy_u  = r_vel_y;
    assign abs_x = vx_u[VEL_WIDTH-1] ? (~vx_u + VEL_WIDTH'(1)) : vx_u;
    assign abs_y = vy_u[VEL_WIDTH-1] ? (~vy_u + VEL_WIDTH'(1)) : vy_u;

    // first pass squares each component, second pass multiplies by speed
    assign mul_start = (in_acc && (in_func == FUNC_RENORM)) ||
                       ((r_state == S_ROOT) && sqrt_done && (root != '0));
    assign mul_b_x   = (r_state == S_ROOT) ? MUL_W'(r_speed) : MUL_W'(abs_x);
    assign mul_b_y   = (r_state == S_ROOT) ? MUL_W'(r_speed) : MUL_W'(abs_y);

    assign sqrt_start = (r_state == S_SQR) && mul_done_x;
    assign radicand   = prod_x[SQ_W-1:0] + prod_y[SQ_W-1:0];
    assign div_start  = (r_state == S_SCALE) && mul_done_x;

    bmr_serial_mul u_mul_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (MUL_W'(abs_x)),
        .i_b       (mul_b_x),
        .o_done    (mul_done_x),
        .o_product (prod_x)
    );

    bmr_serial_mul u_mul_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (MUL_W'(abs_y)),
        .i_b       (mul_b_y),
        .o_done    (mul_done_y),
        .o_product (prod_y)
    );

    bmr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    bmr_serial_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_x[NUM_W-1:0]),
        .i_divisor  (root),
        .o_done     (div_done_x),
        .o_quotient (quot_x)
    );

    bmr_serial_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_y[NUM_W-1:0]),
        .i_divisor  (root),
        .o_done     (div_done_y),
        .o_quotient (quot_y)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (in_func == FUNC_RENORM) ? S_SQR : S_DONE;
                end
            end
            S_SQR: begin
                if (mul_done_x) n_state = S_ROOT;
            end
            S_ROOT: begin
                if (sqrt_done) n_state = (root == '0) ? S_DONE : S_SCALE;
            end
            S_SCALE: begin
                if (mul_done_x) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done_x) n_state = S_DONE;
            end
            S_DONE: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign sum_x = EXT_W'(r_pos_x) + EXT_W'(r_vel_x);
    assign sum_y = EXT_W'(r_pos_y) + EXT_W'(r_vel_y);
    assign ext_a = EXT_W'(r_load_a);
    assign ext_b = EXT_W'(r_load_b);

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        unique case (r_func)
            FUNC_ADVANCE: begin
                if (!r_hold) begin
                    n_pos_x = sat_pos(sum_x);
                    n_pos_y = sat_pos(sum_y);
                end
            end
            FUNC_RENORM: begin
                // zero magnitude leaves velocity as it was
                if (!r_skip) begin
                    n_vel_x = sat_vel(r_vel_x[VEL_WIDTH-1], quot_x);
                    n_vel_y = sat_vel(r_vel_y[VEL_WIDTH-1], quot_y);
                end
            end
            FUNC_LOAD_VEL: begin
                n_vel_x = $signed(ext_a[VEL_WIDTH-1:0]);
                n_vel_y = $signed(ext_b[VEL_WIDTH-1:0]);
            end
            FUNC_LOAD_POS: begin
                n_pos_x = sat_pos(ext_a);
                n_pos_y = sat_pos(ext_b);
            end
            default: begin
                n_pos_x = r_pos_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= SPEED_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_speed <= i_cfg_wdata;
            if (in_acc) begin
                r_skip <= 1'b0;
            end else if ((r_state == S_ROOT) && sqrt_done && (root == '0)) begin
                r_skip <= 1'b1;
            end
            if (commit) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_vel_x     <= n_vel_x;
                r_vel_y     <= n_vel_y;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func   <= in_func;
            r_hold   <= i_s_axis_tuser[2];
            r_load_a <= i_s_axis_tdata[LOAD_WIDTH-1:0];
            r_load_b <= i_s_axis_tdata[2*LOAD_WIDTH-1:LOAD_WIDTH];
        end
        if (commit) begin
            r_out_data <= OUT_DATA_W'({n_vel_y, n_vel_x, n_pos_y, n_pos_x});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `BMR_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && !i_m_axis_tready, r_state == S_DONE, "result overwritten while stalled")
    `BMR_ASSERT_IMPLIES(a_lanes_in_step, i_clk, i_rst_n, mul_done_x || div_done_x, mul_done_y == mul_done_x && div_done_y == div_done_x, "x and y lanes out of step")
    `BMR_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_acc, !o_s_axis_tready, "second request taken while busy")
    `BMR_ASSERT_IMPLIES(a_root_in_phase, i_clk, i_rst_n, sqrt_done, r_state == S_ROOT, "root finished outside its phase")

endmodule
